// ===== hw/rtl/stq_pkg.sv =====
package stq_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int ID_BITS     = 12;
    localparam int ID_PORT_W   = 12;
    localparam int TIME_W      = 32;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        MODE_ADD    = 2'd0,
        MODE_ADJUST = 2'd1,
        MODE_DELETE = 2'd2,
        MODE_TICK   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        KIND_ACK     = 2'd0,
        KIND_EXPIRED = 2'd1,
        KIND_NONE    = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_MISSING   = 2'd2,
        ST_DUPLICATE = 2'd3
    } t_status;

    typedef struct packed {
        logic [TIME_W-1:0]  expiry;
        logic [ID_BITS-1:0] owner;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        t_mode                mode;
        logic [ID_PORT_W-1:0] timer_id;
        logic [TIME_W-1:0]    expire_time;
        logic [TIME_W-1:0]    now_time;
    } t_item;

    typedef struct packed {
        t_kind                kind;
        logic [ID_PORT_W-1:0] out_id;
        t_status              status;
        logic                 last;
    } t_result;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_entry           wdata;
        logic [IDX_W-1:0] raddr;
    } t_mem_req;

    function automatic logic [ID_BITS-1:0] id_from_port(input logic [ID_PORT_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[ID_BITS-1:0];
    endfunction

    function automatic logic [ID_PORT_W-1:0] id_to_port(input logic [ID_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[ID_PORT_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/stq_ram.sv =====
module stq_ram #(
    parameter int WIDTH  = 44,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/stq_ctrl.sv =====
module stq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  stq_pkg::t_item    i_in,
    output stq_pkg::t_mem_req o_mem,
    input  stq_pkg::t_entry   i_rdata,
    input  logic              i_out_free,
    output logic              o_emit,
    output stq_pkg::t_result  o_result
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SHIFT,
        S_WNEW,
        S_ACK,
        S_TRD,
        S_TCMP
    } t_state;

    t_state                             r_state;
    logic [stq_pkg::CNT_W-1:0]          r_count;
    stq_pkg::t_mode                     r_mode;
    logic [stq_pkg::ID_BITS-1:0]        r_id;
    logic [stq_pkg::TIME_W-1:0]         r_time;
    stq_pkg::t_status                   r_status;

    logic [stq_pkg::CNT_W-1:0]          r_si;
    logic                               r_sv;
    logic [stq_pkg::CNT_W-1:0]          r_sidx;
    logic                               r_found;
    logic [stq_pkg::CNT_W-1:0]          r_pos;
    logic [stq_pkg::CNT_W-1:0]          r_lt;

    logic [stq_pkg::CNT_W-1:0]          r_src;
    logic [stq_pkg::CNT_W-1:0]          r_rem;
    logic [stq_pkg::CNT_W-1:0]          r_dist;
    logic                               r_left;
    logic                               r_wv;
    logic [stq_pkg::IDX_W-1:0]          r_wa;
    logic                               r_wnew;
    logic [stq_pkg::CNT_W-1:0]          r_ins;

    logic [stq_pkg::CNT_W-1:0]          r_k;
    logic                               r_pend_v;
    logic [stq_pkg::ID_BITS-1:0]        r_pend_id;

    logic                               w_scan_issue;
    logic                               w_shift_issue;
    logic                               w_hit;
    logic [stq_pkg::CNT_W-1:0]          w_left_dst;
    logic [stq_pkg::CNT_W-1:0]          w_right_dst;

    assign o_in_ready    = (r_state == S_IDLE);
    assign w_scan_issue  = (r_si < r_count);
    assign w_shift_issue = (r_rem != '0);
    assign w_hit         = (r_k < r_count) && (i_rdata.expiry <= r_time);
    assign w_left_dst    = r_src - r_dist;
    assign w_right_dst   = r_src + stq_pkg::CNT_ONE;

    always_comb begin
        o_mem.we    = 1'b0;
        o_mem.waddr = r_wa;
        o_mem.wdata = i_rdata;
        o_mem.raddr = r_k[stq_pkg::IDX_W-1:0];
        unique case (r_state)
            S_SCAN: begin
                o_mem.raddr = r_si[stq_pkg::IDX_W-1:0];
            end
            S_SHIFT: begin
                o_mem.raddr = r_src[stq_pkg::IDX_W-1:0];
                o_mem.we    = r_wv;
            end
            S_WNEW: begin
                o_mem.we           = 1'b1;
                o_mem.waddr        = r_ins[stq_pkg::IDX_W-1:0];
                o_mem.wdata.expiry = r_time;
                o_mem.wdata.owner  = r_id;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_emit          = 1'b0;
        o_result.kind   = stq_pkg::KIND_ACK;
        o_result.out_id = stq_pkg::id_to_port(r_id);
        o_result.status = r_status;
        o_result.last   = 1'b1;
        unique case (r_state)
            S_ACK: begin
                o_emit = i_out_free;
            end
            S_TCMP: begin
                o_result.status = stq_pkg::ST_OK;
                if (w_hit) begin
                    o_emit          = r_pend_v && i_out_free;
                    o_result.kind   = stq_pkg::KIND_EXPIRED;
                    o_result.out_id = stq_pkg::id_to_port(r_pend_id);
                    o_result.last   = 1'b0;
                end else begin
                    o_emit = i_out_free;
                    if (r_pend_v) begin
                        o_result.kind   = stq_pkg::KIND_EXPIRED;
                        o_result.out_id = stq_pkg::id_to_port(r_pend_id);
                    end else begin
                        o_result.kind   = stq_pkg::KIND_NONE;
                        o_result.out_id = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_sv     <= 1'b0;
            r_wv     <= 1'b0;
            r_pend_v <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_mode  <= i_in.mode;
                        r_id    <= stq_pkg::id_from_port(i_in.timer_id);
                        r_si    <= '0;
                        r_sv    <= 1'b0;
                        r_found <= 1'b0;
                        r_pos   <= '0;
                        r_lt    <= '0;
                        r_k     <= '0;
                        r_pend_v <= 1'b0;
                        if (i_in.mode == stq_pkg::MODE_TICK) begin
                            r_time  <= i_in.now_time;
                            r_state <= S_TRD;
                        end else begin
                            r_time  <= i_in.expire_time;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    r_sv   <= w_scan_issue;
                    r_sidx <= r_si;
                    if (w_scan_issue) begin
                        r_si <= r_si + stq_pkg::CNT_ONE;
                    end
                    if (r_sv) begin
                        if (i_rdata.owner == r_id) begin
                            r_found <= 1'b1;
                            r_pos   <= r_sidx;
                        end else if (i_rdata.expiry < r_time) begin
                            r_lt <= r_lt + stq_pkg::CNT_ONE;
                        end
                    end
                    if (!w_scan_issue && !r_sv) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_wv     <= 1'b0;
                    r_dist   <= stq_pkg::CNT_ONE;
                    r_ins    <= r_lt;
                    unique case (r_mode)
                        stq_pkg::MODE_ADD: begin
                            if (r_found) begin
                                r_status <= stq_pkg::ST_DUPLICATE;
                                r_state  <= S_ACK;
                            end else if (r_count == stq_pkg::DEPTH_CNT) begin
                                r_status <= stq_pkg::ST_FULL;
                                r_state  <= S_ACK;
                            end else begin
                                r_status <= stq_pkg::ST_OK;
                                r_left  <= 1'b0;
                                r_src   <= r_count - stq_pkg::CNT_ONE;
                                r_rem   <= r_count - r_lt;
                                r_wnew  <= 1'b1;
                                r_count <= r_count + stq_pkg::CNT_ONE;
                                r_state <= S_SHIFT;
                            end
                        end
                        stq_pkg::MODE_DELETE: begin
                            if (!r_found) begin
                                r_status <= stq_pkg::ST_MISSING;
                                r_state  <= S_ACK;
                            end else begin
                                r_status <= stq_pkg::ST_OK;
                                r_left  <= 1'b1;
                                r_src   <= r_pos + stq_pkg::CNT_ONE;
                                r_rem   <= r_count - stq_pkg::CNT_ONE - r_pos;
                                r_wnew  <= 1'b0;
                                r_count <= r_count - stq_pkg::CNT_ONE;
                                r_state <= S_SHIFT;
                            end
                        end
                        stq_pkg::MODE_ADJUST: begin
                            if (!r_found) begin
                                r_status <= stq_pkg::ST_MISSING;
                                r_state  <= S_ACK;
                            end else begin
                                r_status <= stq_pkg::ST_OK;
                                r_wnew  <= 1'b1;
                                r_state <= S_SHIFT;
                                if (r_lt >= r_pos) begin
                                    r_left <= 1'b1;
                                    r_src  <= r_pos + stq_pkg::CNT_ONE;
                                    r_rem  <= r_lt - r_pos;
                                end else begin
                                    r_left <= 1'b0;
                                    r_src  <= r_pos - stq_pkg::CNT_ONE;
                                    r_rem  <= r_pos - r_lt;
                                end
                            end
                        end
                        stq_pkg::MODE_TICK: begin
                            r_state <= S_IDLE;
                        end
                    endcase
                end
                S_SHIFT: begin
                    r_wv <= w_shift_issue;
                    if (w_shift_issue) begin
                        r_rem <= r_rem - stq_pkg::CNT_ONE;
                        if (r_left) begin
                            r_wa  <= w_left_dst[stq_pkg::IDX_W-1:0];
                            r_src <= r_src + stq_pkg::CNT_ONE;
                        end else begin
                            r_wa  <= w_right_dst[stq_pkg::IDX_W-1:0];
                            r_src <= r_src - stq_pkg::CNT_ONE;
                        end
                    end
                    if (!w_shift_issue && !r_wv) begin
                        priority if (r_wnew) begin
                            r_state <= S_WNEW;
                        end else if (r_mode == stq_pkg::MODE_TICK) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_ACK;
                        end
                    end
                end
                S_WNEW: begin
                    r_state <= S_ACK;
                end
                S_ACK: begin
                    if (i_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                S_TRD: begin
                    r_state <= S_TCMP;
                end
                S_TCMP: begin
                    if (w_hit) begin
                        if (!r_pend_v || i_out_free) begin
                            r_pend_v  <= 1'b1;
                            r_pend_id <= i_rdata.owner;
                            r_k       <= r_k + stq_pkg::CNT_ONE;
                            r_state   <= S_TRD;
                        end
                    end else if (i_out_free) begin
                        r_pend_v <= 1'b0;
                        r_wv     <= 1'b0;
                        r_left   <= 1'b1;
                        r_wnew   <= 1'b0;
                        r_src    <= r_k;
                        r_dist   <= r_k;
                        r_rem    <= (r_k == '0) ? '0 : (r_count - r_k);
                        r_count  <= r_count - r_k;
                        r_state  <= S_SHIFT;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= stq_pkg::DEPTH_CNT)
        else $error("occupancy above queue depth");

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !o_mem.we)
        else $error("memory write while idle");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit |-> i_out_free)
        else $error("result emitted into a full output register");

    a_tick_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TCMP) |=> (r_count <= $past(r_count)))
        else $error("tick grew the queue");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_si <= r_count))
        else $error("scan ran past occupancy");
`endif

endmodule

// ===== hw/rtl/sorted_timeout_queue_top.sv =====
// Channel   Dir  tdata (low bit up)                          tuser       tlast
// s_axis    in   timer_id[11:0] expire_time[43:12]           mode[1:0]   -
//                now_time[75:44] zero[79:76]
// m_axis    out  out_id[11:0] status[13:12] zero[15:14]      kind[1:0]   last
//
// Add, adjust and delete: the result follows a scan of all occupied entries and a shift of the
// moved entries, paced by the single read port and single write port of the timer memory.
// Tick: reads the entries from the head, one expired result per due timer or one empty result,
// then moves any remaining entries down to the head.
// Reset clears the occupancy only; the memory is not swept.
// One result register decouples m_axis; a due result waits only while it is still full.
module sorted_timeout_queue_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // timer_id, expire_time, now_time
    input  logic [1:0]  s_axis_tuser,   // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // out_id, status
    output logic [1:0]  m_axis_tuser,   // kind
    output logic        m_axis_tlast
);

    stq_pkg::t_item     w_item;
    stq_pkg::t_mem_req  w_mem;
    stq_pkg::t_entry    w_rdata;
    stq_pkg::t_result   w_result;
    logic               w_emit;
    logic               w_out_free;
    logic [stq_pkg::ENTRY_W-1:0] w_rdata_raw;

    logic               r_m_tvalid;
    stq_pkg::t_result   r_m_result;

    assign w_item.mode        = stq_pkg::t_mode'(s_axis_tuser);
    assign w_item.timer_id    = s_axis_tdata[11:0];
    assign w_item.expire_time = s_axis_tdata[43:12];
    assign w_item.now_time    = s_axis_tdata[75:44];

    assign w_out_free = !r_m_tvalid || m_axis_tready;
    assign w_rdata    = stq_pkg::t_entry'(w_rdata_raw);

    stq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_in       (w_item),
        .o_mem      (w_mem),
        .i_rdata    (w_rdata),
        .i_out_free (w_out_free),
        .o_emit     (w_emit),
        .o_result   (w_result)
    );

    stq_ram #(
        .WIDTH (stq_pkg::ENTRY_W),
        .DEPTH (stq_pkg::QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem.we),
        .i_waddr (w_mem.waddr),
        .i_wdata (w_mem.wdata),
        .i_raddr (w_mem.raddr),
        .o_rdata (w_rdata_raw)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (w_emit) begin
            r_m_tvalid <= 1'b1;
            r_m_result <= w_result;
        end else if (m_axis_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = {2'b00, r_m_result.status, r_m_result.out_id};
    assign m_axis_tuser  = r_m_result.kind;
    assign m_axis_tlast  = r_m_result.last;

endmodule

// ===== verif/tb_sorted_timeout_queue_top.sv =====
`timescale 1ns / 100ps

module tb_sorted_timeout_queue_top;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;   // timer_id, expire_time, now_time
    logic [1:0]  s_axis_tuser = '0;   // mode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // out_id, status
    logic [1:0]  m_axis_tuser;        // kind
    logic        m_axis_tlast;

    logic [stq_pkg::TIME_W-1:0]  timer_expiry [stq_pkg::QUEUE_DEPTH];
    logic [stq_pkg::ID_BITS-1:0] timer_owner  [stq_pkg::QUEUE_DEPTH];
    int                          live_count = 0;

    stq_pkg::t_result due_results [$];
    stq_pkg::t_result want_result;

    int  error_count    = 0;
    int  words_sent     = 0;
    int  results_seen   = 0;
    int  expired_count  = 0;
    int  none_count     = 0;
    int  reject_count   = 0;
    int  rx_hold_cycles = 0;
    int  longest_hold   = 0;
    bit  quiet_link     = 1'b0;
    logic [stq_pkg::TIME_W-1:0] time_base;

    sorted_timeout_queue_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        if (quiet_link) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic int find_slot(input logic [stq_pkg::ID_BITS-1:0] id);
        for (int i = 0; i < live_count; i++) begin
            if (timer_owner[i] == id) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic void drop_slot(input int pos);
        for (int i = pos; i + 1 < live_count; i++) begin
            timer_expiry[i] = timer_expiry[i + 1];
            timer_owner[i]  = timer_owner[i + 1];
        end
        live_count--;
    endfunction

    function automatic void place_timer(input logic [stq_pkg::ID_BITS-1:0] id,
                                        input logic [stq_pkg::TIME_W-1:0] expiry);
        int pos;
        pos = 0;
        while (pos < live_count && expiry > timer_expiry[pos]) begin
            pos++;
        end
        for (int i = live_count; i > pos; i--) begin
            timer_expiry[i] = timer_expiry[i - 1];
            timer_owner[i]  = timer_owner[i - 1];
        end
        timer_expiry[pos] = expiry;
        timer_owner[pos]  = id;
        live_count++;
    endfunction

    function automatic void predict_timer_word(
        input stq_pkg::t_mode                mode,
        input logic [stq_pkg::ID_PORT_W-1:0] id_in,
        input logic [stq_pkg::TIME_W-1:0]    expiry,
        input logic [stq_pkg::TIME_W-1:0]    now
    );
        logic [stq_pkg::ID_BITS-1:0] id;
        stq_pkg::t_result            res;
        int                          pos;
        id = stq_pkg::ID_BITS'(id_in);
        res.status = stq_pkg::ST_OK;
        res.last   = 1'b1;
        if (mode == stq_pkg::MODE_TICK) begin
            if (live_count == 0 || timer_expiry[0] > now) begin
                res.kind   = stq_pkg::KIND_NONE;
                res.out_id = '0;
                due_results.push_back(res);
                none_count++;
            end
            while (live_count > 0 && timer_expiry[0] <= now) begin
                res.kind   = stq_pkg::KIND_EXPIRED;
                res.out_id = stq_pkg::ID_PORT_W'(timer_owner[0]);
                res.last   = !(live_count > 1 && timer_expiry[1] <= now);
                due_results.push_back(res);
                expired_count++;
                drop_slot(0);
            end
            return;
        end
        pos        = find_slot(id);
        res.kind   = stq_pkg::KIND_ACK;
        res.out_id = stq_pkg::ID_PORT_W'(id);
        if (mode == stq_pkg::MODE_ADD) begin
            if (pos >= 0) begin
                res.status = stq_pkg::ST_DUPLICATE;
            end else if (live_count >= stq_pkg::QUEUE_DEPTH) begin
                res.status = stq_pkg::ST_FULL;
            end else begin
                place_timer(id, expiry);
            end
        end else if (pos < 0) begin
            res.status = stq_pkg::ST_MISSING;
        end else begin
            drop_slot(pos);
            if (mode == stq_pkg::MODE_ADJUST) begin
                place_timer(id, expiry);
            end
        end
        if (res.status != stq_pkg::ST_OK) begin
            reject_count++;
        end
        due_results.push_back(res);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on %s at result %0d: got %0d, want %0d", what, results_seen,
                 got, want);
        error_count++;
    endtask

    task automatic send_word(input stq_pkg::t_mode mode,
                             input logic [stq_pkg::ID_PORT_W-1:0] id,
                             input logic [stq_pkg::TIME_W-1:0] expiry,
                             input logic [stq_pkg::TIME_W-1:0] now);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {4'b0, now, expiry, id};
        s_axis_tuser  = mode;
        do begin
            @(posedge i_clk);
        end while (!(s_axis_tvalid && s_axis_tready));
        predict_timer_word(mode, id, expiry, now);
        words_sent++;
    endtask

    // hold off the receiver on request, otherwise stall at random
    initial begin
        int gap;
        int held;
        forever begin
            @(negedge i_clk);
            if (rx_hold_cycles > 0) begin
                m_axis_tready = 1'b0;
                held = 0;
                while (held < rx_hold_cycles) begin
                    @(negedge i_clk);
                    held++;
                end
                if (held > longest_hold) begin
                    longest_hold = held;
                end
                rx_hold_cycles = 0;
            end else begin
                gap = pick_gap();
                if (gap == 0) begin
                    m_axis_tready = 1'b1;
                end else begin
                    m_axis_tready = 1'b0;
                    repeat (gap - 1) @(negedge i_clk);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (due_results.size() == 0) begin
                report_mismatch("unexpected word", m_axis_tdata, 0);
            end else begin
                want_result = due_results.pop_front();
                if (m_axis_tuser !== want_result.kind) begin
                    report_mismatch("kind", m_axis_tuser, want_result.kind);
                end
                if (m_axis_tdata[11:0] !== want_result.out_id) begin
                    report_mismatch("out_id", m_axis_tdata[11:0], want_result.out_id);
                end
                if (m_axis_tdata[13:12] !== want_result.status) begin
                    report_mismatch("status", m_axis_tdata[13:12], want_result.status);
                end
                if (m_axis_tlast !== want_result.last) begin
                    report_mismatch("last", m_axis_tlast, want_result.last);
                end
            end
        end
    end

    task automatic test_empty_tick();
        send_word(stq_pkg::MODE_TICK, 12'h000, 32'h0, 32'h0);
        send_word(stq_pkg::MODE_TICK, 12'hFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_add_extremes();
        send_word(stq_pkg::MODE_ADD, 12'h000, 32'h0000_0000, 32'h0);
        send_word(stq_pkg::MODE_ADD, 12'hFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(stq_pkg::MODE_ADD, 12'hAAA, 32'h5555_5555, 32'hAAAA_AAAA);
        send_word(stq_pkg::MODE_ADD, 12'h555, 32'hAAAA_AAAA, 32'h5555_5555);
        send_word(stq_pkg::MODE_ADD, 12'hFFF, 32'h0000_0007, 32'h0);
    endtask

    task automatic test_equal_expiry();
        send_word(stq_pkg::MODE_ADD, 12'h010, 32'd1000, 32'h0);
        send_word(stq_pkg::MODE_ADD, 12'h011, 32'd1000, 32'h0);
        send_word(stq_pkg::MODE_ADD, 12'h012, 32'd1000, 32'h0);
    endtask

    task automatic test_adjust();
        send_word(stq_pkg::MODE_ADJUST, 12'hAAA, 32'd1000, 32'h0);
        send_word(stq_pkg::MODE_ADJUST, 12'h000, 32'd2000, 32'h0);
        send_word(stq_pkg::MODE_ADJUST, 12'h077, 32'd5, 32'h0);
    endtask

    task automatic test_delete();
        send_word(stq_pkg::MODE_DELETE, 12'h011, 32'h0, 32'h0);
        send_word(stq_pkg::MODE_DELETE, 12'h011, 32'h0, 32'h0);
    endtask

    task automatic test_tick_partial();
        send_word(stq_pkg::MODE_TICK, 12'h0, 32'h0, 32'd999);
        send_word(stq_pkg::MODE_TICK, 12'h0, 32'h0, 32'd1000);
        send_word(stq_pkg::MODE_TICK, 12'h0, 32'h0, 32'hAAAA_AAAA);
        send_word(stq_pkg::MODE_TICK, 12'h0, 32'h0, 32'hFFFF_FFFF);
    endtask

    task automatic test_full_with_backpressure();
        logic [stq_pkg::ID_PORT_W-1:0] spare_id;
        send_word(stq_pkg::MODE_TICK, 12'h0, 32'h0, 32'hFFFF_FFFF);
        rx_hold_cycles = 400;
        for (int i = 0; i < stq_pkg::QUEUE_DEPTH; i++) begin
            send_word(stq_pkg::MODE_ADD, 12'(i * 64 + $urandom_range(0, 63)), $urandom,
                      $urandom);
        end
        do begin
            spare_id = 12'($urandom);
        end while (find_slot(spare_id) >= 0);
        send_word(stq_pkg::MODE_ADD, spare_id, $urandom, 32'h0);
        send_word(stq_pkg::MODE_ADD,
                  timer_owner[$urandom_range(0, stq_pkg::QUEUE_DEPTH - 1)], 32'h0, 32'h0);
        send_word(stq_pkg::MODE_ADJUST, timer_owner[stq_pkg::QUEUE_DEPTH - 1], 32'h0,
                  32'h0);
        send_word(stq_pkg::MODE_DELETE, timer_owner[5], 32'h0, 32'h0);
        send_word(stq_pkg::MODE_ADD, spare_id, 32'hFFFF_FFFF, 32'h0);
        rx_hold_cycles = 300;
        send_word(stq_pkg::MODE_TICK, 12'h0, 32'h0, 32'hFFFF_FFFF);
    endtask

    function automatic logic [stq_pkg::ID_PORT_W-1:0] pick_timer_id(input bit prefer_live);
        if (prefer_live && live_count > 0 && $urandom_range(0, 9) < 8) begin
            return timer_owner[$urandom_range(0, live_count - 1)];
        end else if ($urandom_range(0, 9) < 7) begin
            return 12'($urandom_range(0, 79));
        end
        return 12'($urandom);
    endfunction

    task automatic test_random_traffic(input int count);
        stq_pkg::t_mode                mode;
        logic [stq_pkg::ID_PORT_W-1:0] id;
        logic [stq_pkg::TIME_W-1:0]    expiry;
        logic [stq_pkg::TIME_W-1:0]    now;
        int                            r;
        time_base = $urandom;
        for (int k = 0; k < count; k++) begin
            quiet_link = (k % 70) >= 52;
            r      = $urandom_range(0, 99);
            id     = pick_timer_id(r >= 35 && r < 70);
            expiry = ($urandom_range(0, 9) == 0) ? $urandom
                                                 : time_base + $urandom_range(0, 300);
            now    = $urandom;
            if (r < 35) begin
                mode = stq_pkg::MODE_ADD;
            end else if (r < 52) begin
                mode = stq_pkg::MODE_ADJUST;
            end else if (r < 70) begin
                mode = stq_pkg::MODE_DELETE;
            end else begin
                mode = stq_pkg::MODE_TICK;
                if ($urandom_range(0, 99) >= 8) begin
                    now       = time_base + $urandom_range(0, 120);
                    time_base = now;
                end
            end
            send_word(mode, id, expiry, now);
        end
        quiet_link = 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_tick();
        test_add_extremes();
        test_equal_expiry();
        test_adjust();
        test_delete();
        test_tick_partial();
        test_full_with_backpressure();
        test_random_traffic(120);

        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (due_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (2 * stq_pkg::QUEUE_DEPTH + 40) @(posedge i_clk);

        $display("covered %0d words of all four modes, a full queue and a %0d-cycle hold",
                 words_sent, longest_hold);
        $display("checked %0d results: %0d expiries, %0d empty ticks, %0d rejected requests",
                 results_seen, expired_count, none_count, reject_count);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("timeout with %0d results outstanding", due_results.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
